/* hdl/fbs_pkg.sv */
// fbs_pkg: shared types, constants and the crc-8 step for the framed serializer
// used by every module of framed_bit_serializer_crc8; depends on nothing
package fbs_pkg;

  // default frame lengths, handed to the top level parameters
  localparam int unsigned PREAMBLE_LEN_DEF = 16;
  localparam int unsigned TRAILER_LEN_DEF  = 10;

  // crc-8, polynomial x^8 + x^2 + x + 1, msb first, initial value zero
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // start bit, eight data bits, stop bit
  localparam int unsigned FRAME_BITS = 10;
  localparam logic        START_BIT  = 1'b0;
  localparam logic        STOP_BIT   = 1'b1;
  localparam logic        IDLE_BIT   = 1'b1;

  // job queue between front and back
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } fbs_in_t;

  // output word, one line bit
  typedef struct packed {
    logic line_bit;
    logic run_last;
    logic block_done;
  } fbs_out_t;

  // one classified byte waiting for the serializer
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] crc;        // crc including this byte, sent when last is set
    logic       first;      // preamble goes out ahead of this byte
    logic       last;       // crc frame and trailer follow this byte
  } fbs_job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fbs_qstat_t;

  // serializer phases
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_DATA = 5'b00100,
    ST_CRC  = 5'b01000,
    ST_TRL  = 5'b10000
  } fbs_state_t;

  // crc over one byte, eight shift steps
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/fbs_front.sv */
// fbs_front: accepts input words, keeps the running crc and block position,
// and builds one job per byte; depends on fbs_pkg
module fbs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fbs_pkg::fbs_in_t    in_data,
  output logic                in_stall,
  input  fbs_pkg::fbs_qstat_t q_stat,
  output logic                push,
  output fbs_pkg::fbs_job_t   push_job
);

  logic [7:0] crc_r, crc_nxt;
  logic       inside_r, inside_nxt;
  logic [7:0] crc_upd;

  // accept whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  // classify the byte and fold it into the crc
  assign crc_upd            = fbs_pkg::crc_update(crc_r, in_data.data_byte);
  assign push_job.data_byte = in_data.data_byte;
  assign push_job.crc       = crc_upd;
  assign push_job.first     = ~inside_r;
  assign push_job.last      = in_data.last_byte;

  // block state: crc restarts after the last byte
  always_comb begin
    crc_nxt    = crc_r;
    inside_nxt = inside_r;
    if (push) begin
      crc_nxt    = in_data.last_byte ? fbs_pkg::CRC_INIT : crc_upd;
      inside_nxt = ~in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= fbs_pkg::CRC_INIT;
      inside_r <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

/* hdl/fbs_queue.sv */
// fbs_queue: small first-in first-out store of jobs between front and back
// depends on fbs_pkg
module fbs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbs_pkg::fbs_job_t   push_job,
  input  logic                pop,
  output fbs_pkg::fbs_job_t   pop_job,
  output fbs_pkg::fbs_qstat_t q_stat
);

  localparam int unsigned AW = fbs_pkg::QUEUE_AW;
  localparam int unsigned CW = AW + 1;

  fbs_pkg::fbs_job_t mem_r [fbs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(fbs_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign pop_job      = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/fbs_back.sv */
// fbs_back: takes jobs from the queue, sends preamble, byte frame, crc frame and
// trailer to the output register, one bit per unstalled cycle; depends on fbs_pkg
module fbs_back #(
  parameter int unsigned PREAMBLE_LEN = fbs_pkg::PREAMBLE_LEN_DEF,
  parameter int unsigned TRAILER_LEN  = fbs_pkg::TRAILER_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fbs_pkg::fbs_qstat_t q_stat,
  input  fbs_pkg::fbs_job_t   pop_job,
  output logic                pop,
  output logic                out_valid,
  output fbs_pkg::fbs_out_t   out_data,
  input  logic                out_stall
);

  localparam int unsigned MAX_A   = (PREAMBLE_LEN > TRAILER_LEN) ? PREAMBLE_LEN : TRAILER_LEN;
  localparam int unsigned MAX_LEN = (MAX_A > fbs_pkg::FRAME_BITS) ? MAX_A : fbs_pkg::FRAME_BITS;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN);

  fbs_pkg::fbs_state_t st_r, st_nxt, adv_st;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, adv_cnt;
  fbs_pkg::fbs_job_t   job_r;
  logic                out_valid_r, out_valid_nxt;
  fbs_pkg::fbs_out_t   out_data_r, out_data_nxt;
  fbs_pkg::fbs_out_t   cur_bit;
  logic                emit, end_job;
  logic                frame_end, frame_bit;
  logic [7:0]          frame_byte;
  logic [2:0]          bit_idx;

  // a bit goes out when the output register is free or being taken
  assign emit = (st_r != fbs_pkg::ST_IDLE) && (!out_valid_r || !out_stall);

  // start and stop bit around eight data bits, lsb first
  assign frame_byte = (st_r == fbs_pkg::ST_CRC) ? job_r.crc : job_r.data_byte;
  assign bit_idx    = 3'(cnt_r - CNT_W'(1));
  assign frame_end  = (cnt_r == CNT_W'(fbs_pkg::FRAME_BITS - 1));
  always_comb begin
    if (cnt_r == '0) begin
      frame_bit = fbs_pkg::START_BIT;
    end else if (frame_end) begin
      frame_bit = fbs_pkg::STOP_BIT;
    end else begin
      frame_bit = frame_byte[bit_idx];
    end
  end

  // current bit and phase advance
  always_comb begin
    adv_st           = st_r;
    adv_cnt          = cnt_r + 1'b1;
    end_job          = 1'b0;
    cur_bit.line_bit   = fbs_pkg::IDLE_BIT;
    cur_bit.run_last   = 1'b0;
    cur_bit.block_done = 1'b0;
    unique case (st_r)
      fbs_pkg::ST_IDLE: begin
        adv_cnt = cnt_r;
      end
      fbs_pkg::ST_PRE: begin
        if (cnt_r == CNT_W'(PREAMBLE_LEN - 1)) begin
          adv_st  = fbs_pkg::ST_DATA;
          adv_cnt = '0;
        end
      end
      fbs_pkg::ST_DATA: begin
        cur_bit.line_bit = frame_bit;
        if (frame_end) begin
          adv_cnt = '0;
          if (job_r.last) begin
            adv_st = fbs_pkg::ST_CRC;
          end else begin
            end_job          = 1'b1;
            cur_bit.run_last = 1'b1;
          end
        end
      end
      fbs_pkg::ST_CRC: begin
        cur_bit.line_bit = frame_bit;
        if (frame_end) begin
          adv_st  = fbs_pkg::ST_TRL;
          adv_cnt = '0;
        end
      end
      fbs_pkg::ST_TRL: begin
        if (cnt_r == CNT_W'(TRAILER_LEN - 1)) begin
          end_job            = 1'b1;
          cur_bit.run_last   = 1'b1;
          cur_bit.block_done = 1'b1;
        end
      end
      default: begin
        adv_st = fbs_pkg::ST_IDLE;
      end
    endcase
  end

  // next job loads while idle or in the cycle the previous one sends its final bit
  assign pop = !q_stat.empty && ((st_r == fbs_pkg::ST_IDLE) || (emit && end_job));

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      st_nxt  = pop_job.first ? fbs_pkg::ST_PRE : fbs_pkg::ST_DATA;
      cnt_nxt = '0;
    end else if (emit) begin
      st_nxt  = end_job ? fbs_pkg::ST_IDLE : adv_st;
      cnt_nxt = end_job ? '0 : adv_cnt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cur_bit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= fbs_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      job_r <= pop_job;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/framed_bit_serializer_crc8.sv */
// framed_bit_serializer_crc8: top level, front classifier, job queue, serializer
// depends on fbs_pkg, fbs_front, fbs_queue, fbs_back
//
// Usage
//   Input channel (in_valid, in_data, in_stall) takes one payload byte per word;
//   in_data.last_byte marks the end of a block. Blocks hold at least one byte.
//   Output channel (out_valid, out_data, out_stall) gives one line bit per word:
//   a preamble of PREAMBLE_LEN ones ahead of the first byte of a block, each byte
//   as start bit, eight data bits lsb first and stop bit, and after the last byte
//   the crc-8 (poly 0x07, init 0) framed the same way and TRAILER_LEN ones.
//   run_last flags the final bit caused by a byte, block_done the final trailer bit.
// Timing
//   The serializer sends one bit per cycle while out_stall does not hold it. When the
//   serializer is idle, an accepted byte passes through the job queue, the job register
//   and the output register before its first bit appears.
//   A 4-entry job queue lets bytes be accepted ahead while bits are still going out;
//   in_stall rises only when that queue is full.
// Reset and stall
//   Reset empties the queue, clears the crc and starts a new block. While out_stall
//   is high while out_valid is set, the current bit holds on out_data and the serializer waits.
module framed_bit_serializer_crc8 #(
  parameter int unsigned PREAMBLE_LEN = fbs_pkg::PREAMBLE_LEN_DEF,
  parameter int unsigned TRAILER_LEN  = fbs_pkg::TRAILER_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fbs_pkg::fbs_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output fbs_pkg::fbs_out_t out_data,
  input  logic              out_stall
);

  fbs_pkg::fbs_qstat_t q_stat;
  fbs_pkg::fbs_job_t   push_job, pop_job;
  logic                push, pop;

  // byte classification and crc
  fbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  fbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // bit serializer
  fbs_back #(
    .PREAMBLE_LEN (PREAMBLE_LEN),
    .TRAILER_LEN  (TRAILER_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* hdl/fbs_checker.sv */
// fbs_checker: port-level checks of the framed serializer output stream
// depends on fbs_pkg; bound to framed_bit_serializer_crc8
module fbs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input fbs_pkg::fbs_in_t  in_data,
  input logic              in_stall,
  input logic              out_valid,
  input fbs_pkg::fbs_out_t out_data,
  input logic              out_stall
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed under stall");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  // end of block is also the end of a byte's run
  a_done_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_done |-> out_data.run_last)
    else $error("block_done without run_last");

  // a byte's run ends on a stop bit or a trailer bit, both ones
  a_run_end_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_last |-> out_data.line_bit)
    else $error("run ends on a zero bit");

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind framed_bit_serializer_crc8 fbs_checker u_fbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);
